>>> rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 engine package
// Shared constants, state codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package sha512_pkg;

  localparam int unsigned NumRounds = 80;

  // Controller states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // Source of the word written into the block buffer.
  localparam logic [1:0] SRC_MSG  = 2'd0;
  localparam logic [1:0] SRC_ZERO = 2'd1;
  localparam logic [1:0] SRC_LENH = 2'd2;
  localparam logic [1:0] SRC_LENL = 2'd3;

  typedef struct packed {
    logic       push;       // write one word into the block buffer
    logic [1:0] push_src;   // which word to write
    logic       pad_flag;   // pushed short message word gets the 0x80 marker; in a zero word, marker already placed
    logic       add_len;    // add the word's bits to the length counter
    logic       start;      // load working variables from chain value
    logic       round;      // run one compression round
    logic       fold;       // add working variables into chain value
    logic       shift_out;  // rotate chain value for digest output
    logic       restart;    // return to initial hash values
  } sha512_cmd_t;

  typedef struct packed {
    logic [3:0] words;      // words held in the current block
  } sha512_sts_t;

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [NumRounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage

>>> rtl/sha512_datapath.sv
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Block buffer with rolling message schedule, one round per cycle, chain
// value and 128-bit length counter.
// ----------------------------------------------------------------------------
module sha512_datapath import sha512_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sha512_cmd_t cmd,
  input  logic [63:0] msg_word,
  input  logic [3:0]  msg_bytes,
  input  logic [6:0]  round_idx,
  output sha512_sts_t sts,
  output logic [63:0] digest_head
);

  logic [63:0] wbuf_r [16];
  logic [63:0] chain_r [8];
  logic [63:0] var_r [8];
  logic [3:0]  words_r;
  logic [127:0] len_r;

  logic [63:0] keep_mask;
  logic [63:0] marker;
  logic [63:0] push_word;
  logic [63:0] sig0, sig1, w_new;
  logic [63:0] t1, t2, a, e;
  logic [6:0]  bits_add;

  assign sts.words   = words_r;
  assign digest_head = chain_r[0];

  // Masking and padding marker for a short final word, and choice of the pushed word.
  always_comb begin
    keep_mask = '1;
    marker    = '0;
    bits_add  = 7'd64;
    if (cmd.pad_flag) begin
      if (msg_bytes < 4'd8) begin
        keep_mask = ~(64'hffff_ffff_ffff_ffff >> {msg_bytes[2:0], 3'b000});
        marker    = 64'h8000_0000_0000_0000 >> {msg_bytes[2:0], 3'b000};
        bits_add  = {1'b0, msg_bytes[2:0], 3'b000};
      end
    end
    unique case (cmd.push_src)
      SRC_MSG:  push_word = (msg_word & keep_mask) | marker;
      SRC_ZERO: push_word = 64'h8000_0000_0000_0000 & {64{!cmd.pad_flag}};
      SRC_LENH: push_word = len_r[127:64];
      SRC_LENL: push_word = len_r[63:0];
      default:  push_word = '0;
    endcase
  end

  // Message schedule from the 16-word window, and the round function.
  always_comb begin
    sig0 = {wbuf_r[1][0], wbuf_r[1][63:1]} ^ {wbuf_r[1][7:0], wbuf_r[1][63:8]}
         ^ (wbuf_r[1] >> 7);
    sig1 = {wbuf_r[14][18:0], wbuf_r[14][63:19]} ^ {wbuf_r[14][60:0], wbuf_r[14][63:61]}
         ^ (wbuf_r[14] >> 6);
    w_new = sig1 + wbuf_r[9] + sig0 + wbuf_r[0];
    a  = var_r[0];
    e  = var_r[4];
    t1 = var_r[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
       + ((e & var_r[5]) ^ (~e & var_r[6])) + RoundK[round_idx] + wbuf_r[0];
    t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
       + ((a & var_r[1]) ^ (a & var_r[2]) ^ (var_r[1] & var_r[2]));
  end

  // Block buffer: filled in order, then rotated once per round.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      wbuf_r[words_r] <= push_word;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) wbuf_r[i] <= wbuf_r[i+1];
      wbuf_r[15] <= w_new;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) var_r[i] <= chain_r[i];
    end else if (cmd.round) begin
      var_r[0] <= t1 + t2;
      var_r[1] <= var_r[0];
      var_r[2] <= var_r[1];
      var_r[3] <= var_r[2];
      var_r[4] <= var_r[3] + t1;
      var_r[5] <= var_r[4];
      var_r[6] <= var_r[5];
      var_r[7] <= var_r[6];
    end
  end

  // Chain value, word counter and length counter.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= InitHash[i];
      words_r <= '0;
      len_r   <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + var_r[i];
      end else if (cmd.shift_out) begin
        for (int i = 0; i < 7; i++) chain_r[i] <= chain_r[i+1];
        chain_r[7] <= chain_r[0];
      end
      if (cmd.push) begin
        words_r <= words_r + 4'd1;
      end
      if (cmd.add_len) begin
        len_r <= len_r + {121'd0, bits_add};
      end
    end
  end

endmodule

>>> rtl/sha512_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-512 controller
// Sequences word intake, padding, the 80 rounds and digest output.
// ----------------------------------------------------------------------------
module sha512_ctrl import sha512_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        in_last,
  input  logic [3:0]  in_bytes,
  input  logic        out_free,
  input  sha512_sts_t sts,
  output logic        in_ready,
  output logic        out_load,
  output logic [2:0]  out_idx,
  output logic [6:0]  round_idx,
  output sha512_cmd_t cmd
);

  logic [2:0] state_r, state_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic       final_r, final_nxt;   // message ended, padding in progress
  logic       marked_r, marked_nxt; // 0x80 marker already placed
  logic [2:0] oidx_r, oidx_nxt;
  logic       short_last;
  logic       lens_in_r;            // high length word already placed

  assign round_idx  = rnd_r;
  assign out_idx    = oidx_r;
  assign in_ready   = (state_r == ST_IDLE);
  assign short_last = in_last && (in_bytes < 4'd8);

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    final_nxt  = final_r;
    marked_nxt = marked_r;
    oidx_nxt   = oidx_r;
    cmd        = '0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.push     = 1'b1;
          cmd.push_src = SRC_MSG;
          cmd.pad_flag = short_last;
          cmd.add_len  = 1'b1;
          final_nxt    = in_last;
          marked_nxt   = short_last;
          if (sts.words == 4'd15) begin
            cmd.start = 1'b1;
            rnd_nxt   = '0;
            state_nxt = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // Marker word, zero fill, then the two length words.
        cmd.push     = 1'b1;
        cmd.pad_flag = marked_r;
        marked_nxt   = 1'b1;
        if (sts.words == 4'd14 && marked_r) begin
          cmd.push_src = SRC_LENH;
        end else if (sts.words == 4'd15 && lens_in_r) begin
          cmd.push_src = SRC_LENL;
        end else begin
          cmd.push_src = SRC_ZERO;
        end
        if (sts.words == 4'd15) begin
          cmd.start = 1'b1;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == 7'(NumRounds - 1)) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        oidx_nxt = '0;
        if (!final_r) begin
          state_nxt = ST_IDLE;
        end else if (marked_r && sts.words == 4'd0 && rnd_r == 7'(NumRounds)
                     && lens_in_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          cmd.shift_out = 1'b1;
          oidx_nxt      = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cmd.restart = 1'b1;
            final_nxt   = 1'b0;
            marked_nxt  = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The length words belong to the block in which the high word went in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lens_in_r <= 1'b0;
    end else if (cmd.restart) begin
      lens_in_r <= 1'b0;
    end else if (cmd.push && cmd.push_src == SRC_LENH) begin
      lens_in_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rnd_r    <= '0;
      final_r  <= 1'b0;
      marked_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      final_r  <= final_nxt;
      marked_r <= marked_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

endmodule

>>> rtl/sha512_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Hashes one message at a time and streams out the eight digest words.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries 64-bit big-endian message words; in_tuser gives
//   the valid byte count (used only on the last word, left-aligned) and
//   in_tlast marks the final word of a message.
//   Each input transfer writes one word of the 16-word block buffer; the
//   sixteenth word starts 80 rounds at one round per cycle, then the fold
//   into the chain value; no input is taken until the fold is done, so
//   the throughput is set by the single round unit.
//   On the last word the engine adds the padding and the 128-bit length,
//   writing pad words one at a time, plus an extra block if needed, then
//   offers the eight digest words on the output stream, word 0 first, with
//   out_tlast on the eighth. A stalled receiver holds the engine in output;
//   no input is taken until the eighth digest word is in the output register.
//   After the last digest word the engine returns to the initial hash values.
//   Reset (rst_n low, synchronous) clears the controller, the length and the
//   chain value; the block buffer needs no clearing.
// ----------------------------------------------------------------------------
module sha512_hash_engine import sha512_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // message_word
  input  logic [3:0]  in_tuser,   // byte_count
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // digest_last
);

  sha512_cmd_t cmd;
  sha512_sts_t sts;
  logic        in_fire, out_load, out_free;
  logic [2:0]  out_idx;
  logic [6:0]  round_idx;
  logic [63:0] digest_head;
  logic [63:0] odata_r;
  logic [2:0]  oidx_r;
  logic        ovalid_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;

  sha512_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_tlast),
    .in_bytes  (in_tuser),
    .out_free  (out_free),
    .sts       (sts),
    .in_ready  (in_tready),
    .out_load  (out_load),
    .out_idx   (out_idx),
    .round_idx (round_idx),
    .cmd       (cmd)
  );

  sha512_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .msg_word    (in_tdata),
    .msg_bytes   (in_tuser),
    .round_idx   (round_idx),
    .sts         (sts),
    .digest_head (digest_head)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= digest_head;
      oidx_r  <= out_idx;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

endmodule
